[rtl/smx_pkg.sv]
// shared types and constants for the stack machine execute block
// no dependencies
package smx_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int ERR_W       = 2;
    localparam int LEVEL_W     = 11;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam logic [FUNC_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [FUNC_W-1:0] OP_POP   = 3'd1;
    localparam logic [FUNC_W-1:0] OP_ADD   = 3'd2;
    localparam logic [FUNC_W-1:0] OP_SUB   = 3'd3;
    localparam logic [FUNC_W-1:0] OP_PRINT = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_BADOP = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0]  top_value;
        logic               value_shown;
        logic [ERR_W-1:0]   error_code;
        logic [LEVEL_W-1:0] stack_level;
    } res_t;

endpackage

[rtl/stack_machine_execute.sv]
// stack machine execute: an instruction is registered into execute, its result
// into the result beat register; no new one is accepted during execute: the accept
// cycle reads the 2nd element from the stack ram, the next executes and writes back
// reset (async, active low) empties the stack; ram contents are not cleared
// input stalls while the result register holds a beat not yet taken
// depends on smx_pkg, smx_exec, smx_ram, smx_obuf
module stack_machine_execute
    import smx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream: one instruction per beat
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // func[2:0], push_value[34:3], zero fill
    // result stream: one result per instruction
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // top_value[31:0], value_shown[32],
                                              // error_code[34:33], stack_level[45:35]
);

    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] push_value;
    logic              out_free;
    logic              res_valid;
    res_t              res;

    // unpack the instruction beat
    assign func       = s_tdata[FUNC_W-1:0];
    assign push_value = s_tdata[FUNC_W +: DATA_W];

    // count, cached top element and stack memory
    smx_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .func       (func),
        .push_value (push_value),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result beat register, free once its beat is taken
    smx_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/smx_ram.sv]
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
module smx_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/smx_exec.sv]
// instruction execution: element count, cached top element, stack ram
// depends on smx_pkg and smx_ram
module smx_exec
    import smx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic [DATA_W-1:0] push_value,
    input  logic              out_free,
    output logic              res_valid,
    output res_t              res
);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [FUNC_W-1:0] op_reg;
    logic [DATA_W-1:0] val_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CNT_W-1:0]  below_top;
    logic [CNT_W-1:0]  second;
    logic [DATA_W-1:0] rd_data;

    assign below_top = count_reg - CNT_W'(1);
    assign second    = count_reg - CNT_W'(2);
    assign waddr     = below_top[ADDR_W-1:0];

    // memory holds elements below the top, the top lives in top_reg
    smx_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_W),
        .AW    (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (top_reg),
        .raddr (second[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign res_valid = (state_reg == ST_EXEC);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        we              = 1'b0;
        res.top_value   = '0;
        res.value_shown = 1'b0;
        res.error_code  = ERR_NONE;
        if (state_reg == ST_IDLE)
        begin
            if (in_valid && in_ready)
            begin
                state_next = ST_EXEC;
            end
        end
        else
        begin
            state_next = ST_IDLE;
            case (op_reg)
                OP_PUSH:
                begin
                    if (count_reg == CNT_W'(STACK_DEPTH))
                    begin
                        res.error_code = ERR_OVER;
                    end
                    else
                    begin
                        we         = (count_reg != '0);
                        top_next   = val_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_POP:
                begin
                    if (count_reg == '0)
                    begin
                        res.error_code = ERR_UNDER;
                    end
                    else
                    begin
                        top_next   = rd_data;
                        count_next = below_top;
                    end
                end
                OP_ADD, OP_SUB:
                begin
                    if (count_reg < CNT_W'(2))
                    begin
                        res.error_code = ERR_UNDER;
                    end
                    else
                    begin
                        top_next   = (op_reg == OP_ADD) ? rd_data + top_reg
                                                        : rd_data - top_reg;
                        count_next = below_top;
                    end
                end
                OP_PRINT:
                begin
                    if (count_reg == '0)
                    begin
                        res.error_code = ERR_UNDER;
                    end
                    else
                    begin
                        res.top_value   = top_reg;
                        res.value_shown = 1'b1;
                    end
                end
                default:
                begin
                    res.error_code = ERR_BADOP;
                end
            endcase
        end
        res.stack_level = LEVEL_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (in_valid && in_ready)
        begin
            op_reg  <= func;
            val_reg <= push_value;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_err_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.error_code != ERR_NONE) |=> count_reg == $past(count_reg))
        else $error("failed instruction changed the count");

    a_print_top: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.value_shown) |->
            (res.error_code == ERR_NONE && res.top_value == top_reg
             && count_reg != '0))
        else $error("print result inconsistent with cached top");

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> (state_reg == ST_IDLE))
        else $error("execute state held more than one cycle");
`endif

endmodule

[rtl/smx_obuf.sv]
// output beat register between execution and the result stream
// depends on smx_pkg
module smx_obuf
    import smx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   res_valid,
    input  res_t                   res,
    output logic                   out_free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic valid_reg, valid_next;
    res_t data_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, data_reg.stack_level, data_reg.error_code,
                       data_reg.value_shown, data_reg.top_value};

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

[verif/stack_machine_execute_checker.sv]
`timescale 1ns / 1ps
// checker for stack_machine_execute: watches both streams, keeps its own stack
// copy to predict each result and compares results field by field
// depends on smx_pkg
module stack_machine_execute_checker
    import smx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // func[2:0], push_value[34:3], zero fill
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,    // top_value[31:0], value_shown[32],
                                               // error_code[34:33], stack_level[45:35]
    output int                     mismatch_count,
    output int                     results_pending
);

    localparam int SHOWN_BIT = DATA_W;
    localparam int ERR_LSB   = DATA_W + 1;
    localparam int LEVEL_LSB = DATA_W + 1 + ERR_W;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    int                depth_now;
    res_t              expected_results [$];

    // executes one instruction on the local stack copy
    function automatic res_t execute_instr(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] val);
        res_t              r;
        logic [DATA_W-1:0] upper;
        logic [DATA_W-1:0] lower;
        r = '0;
        case (op)
            OP_PUSH:
                if (depth_now >= STACK_DEPTH)
                    r.error_code = ERR_OVER;
                else
                begin
                    stack_mem[depth_now] = val;
                    depth_now++;
                end
            OP_POP:
                if (depth_now < 1)
                    r.error_code = ERR_UNDER;
                else
                    depth_now--;
            OP_ADD, OP_SUB:
                if (depth_now < 2)
                    r.error_code = ERR_UNDER;
                else
                begin
                    upper = stack_mem[depth_now - 1];
                    lower = stack_mem[depth_now - 2];
                    stack_mem[depth_now - 2] = (op == OP_ADD) ? lower + upper : lower - upper;
                    depth_now--;
                end
            OP_PRINT:
                if (depth_now < 1)
                    r.error_code = ERR_UNDER;
                else
                begin
                    r.top_value   = stack_mem[depth_now - 1];
                    r.value_shown = 1'b1;
                end
            default:
                r.error_code = ERR_BADOP;
        endcase
        r.stack_level = depth_now[LEVEL_W-1:0];
        return r;
    endfunction

    task automatic compare_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            depth_now = 0;
            expected_results.delete();
            results_pending <= 0;
        end
        else
        begin
            // check first: a result never belongs to an instruction taken at the same edge
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result beat with nothing expected, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("top_value", want.top_value, m_tdata[DATA_W-1:0]);
                    compare_field("value_shown", DATA_W'(want.value_shown),
                                  DATA_W'(m_tdata[SHOWN_BIT]));
                    compare_field("error_code", DATA_W'(want.error_code),
                                  DATA_W'(m_tdata[ERR_LSB +: ERR_W]));
                    compare_field("stack_level", DATA_W'(want.stack_level),
                                  DATA_W'(m_tdata[LEVEL_LSB +: LEVEL_W]));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(execute_instr(s_tdata[FUNC_W-1:0],
                                                         s_tdata[FUNC_W +: DATA_W]));
            results_pending <= expected_results.size();
        end
    end

endmodule

[verif/stack_machine_execute_test.sv]
`timescale 1ns / 1ps
// top of the stack_machine_execute testbench: clock, reset, instruction
// stimulus, result back-pressure and the final verdict
// depends on smx_pkg, stack_machine_execute, stack_machine_execute_checker
module stack_machine_execute_test
    import smx_pkg::*;
();

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // func[2:0], push_value[34:3], zero fill
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // top_value[31:0], value_shown[32],
                                        // error_code[34:33], stack_level[45:35]
    int                     mismatch_count;
    int                     results_pending;

    // steering only: rough element count so the stimulus can reach a full stack
    int                     fill_level;
    int                     beats_sent;
    bit                     sender_calm;

    stack_machine_execute dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    stack_machine_execute_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard limit, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // one instruction beat, preceded by a random gap unless in a calm stretch
    task automatic issue_instr(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] val);
        int gap;
        if (beats_sent % 97 == 0)
            sender_calm = ($urandom_range(0, 3) == 0);
        gap = sender_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - FUNC_W - DATA_W){1'b0}}, val, op};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        beats_sent++;
        case (op)
            OP_PUSH:        if (fill_level < STACK_DEPTH) fill_level++;
            OP_POP:         if (fill_level >= 1) fill_level--;
            OP_ADD, OP_SUB: if (fill_level >= 2) fill_level--;
            default:        ;
        endcase
    endtask

    // random data word, with a bias toward the signed extremes
    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // random instruction; push_pct sets the drift of the stack depth
    task automatic issue_random(int push_pct);
        logic [FUNC_W-1:0] op;
        if ($urandom_range(0, 99) < push_pct)
            op = OP_PUSH;
        else
            case ($urandom_range(0, 9))
                0, 1:    op = OP_POP;
                2, 3:    op = OP_ADD;
                4, 5:    op = OP_SUB;
                6, 7, 8: op = OP_PRINT;
                default: op = FUNC_W'($urandom_range(OP_PRINT + 1, 7));
            endcase
        issue_instr(op, random_word());
    endtask

    // result side: random stalls per beat, calm stretches, one long hold-off
    initial
    begin : result_side
        int hold;
        int beats_taken;
        bit calm;
        beats_taken = 0;
        calm        = 1'b0;
        m_tready    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (beats_taken % 89 == 0)
                calm = ($urandom_range(0, 3) == 0);
            hold = calm ? 0 : $urandom_range(0, 4);
            // long hold-off so the block backs up and stalls its input
            if (beats_taken == 200)
                hold = 300;
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            beats_taken++;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        fill_level  = 0;
        beats_sent  = 0;
        sender_calm = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // print, pop, add and sub on an empty stack all underflow
        issue_instr(OP_PRINT, random_word());
        issue_instr(OP_POP, random_word());
        issue_instr(OP_ADD, random_word());
        issue_instr(OP_SUB, random_word());
        // unknown opcodes
        issue_instr(3'd5, $urandom);
        issue_instr(3'd6, $urandom);
        issue_instr(3'd7, $urandom);
        // add with a single element underflows, then positive wrap on add
        issue_instr(OP_PUSH, 32'h7fff_ffff);
        issue_instr(OP_ADD, $urandom);
        issue_instr(OP_PUSH, 32'h0000_0001);
        issue_instr(OP_ADD, $urandom);
        issue_instr(OP_PRINT, $urandom);
        // most negative value minus itself, then zero minus minus one
        issue_instr(OP_PUSH, 32'h8000_0000);
        issue_instr(OP_SUB, $urandom);
        issue_instr(OP_PRINT, $urandom);
        issue_instr(OP_PUSH, 32'hffff_ffff);
        issue_instr(OP_SUB, $urandom);
        issue_instr(OP_PRINT, $urandom);
        issue_instr(OP_POP, $urandom);
        issue_instr(OP_PRINT, $urandom);
        // alternating bit patterns
        issue_instr(OP_PUSH, 32'haaaa_aaaa);
        issue_instr(OP_PUSH, 32'h5555_5555);
        issue_instr(OP_ADD, $urandom);
        issue_instr(OP_PRINT, $urandom);
        issue_instr(OP_POP, $urandom);

        // shallow stack: frequent underflow
        repeat (150) issue_random(45);
        // climb to a full stack with mixed work on the way
        while (fill_level < STACK_DEPTH)
            issue_random(92);
        // hover at full depth: overflowing pushes, arithmetic on the deepest entries
        repeat (60) issue_random(60);
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (results_pending != 0);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && results_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/smx_pkg.sv
rtl/smx_ram.sv
rtl/smx_exec.sv
rtl/smx_obuf.sv
rtl/stack_machine_execute.sv
verif/stack_machine_execute_checker.sv
verif/stack_machine_execute_test.sv
